/* hw/rtl/lav_pkg.sv */
// lav_pkg: shared widths and register indexes for the look-at view matrix block
// no dependencies
package lav_pkg;

  localparam int FIELD_W = 32;  // width of every port field
  localparam int MAG_W   = 31;  // magnitudes are scaled below 2^31 before the length
  localparam int ROOT_W  = 32;  // floor square root of a sum of three squares
  localparam int SUMSQ_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_UP_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z = 3'd5;

endpackage

/* hw/rtl/lav_norm.sv */
// lav_norm: pipelined 3-vector normalizer, one bit of root and quotient per stage
// depends on lav_pkg
module lav_norm
  import lav_pkg::*;
#(
  parameter int AW        = 32,
  parameter int FRAC_BITS = 16,
  parameter int SW        = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0][AW-1:0]          in_a,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [2:0][FRAC_BITS+1:0]   out_r,
  output logic                        out_zero,
  output logic [SW-1:0]               out_side
);

  localparam int RW    = FRAC_BITS + 2;
  localparam int NS    = FRAC_BITS + 1;
  localparam int SHW   = $clog2(AW + 1);
  localparam int REM_W = MAG_W + 3;

  // scale magnitudes below 2^31
  logic [AW-1:0]       mag_c [3];
  logic [AW-1:0]       or_c;
  logic [SHW-1:0]      hb_c;
  logic [SHW-1:0]      sh_c;
  logic [AW+MAG_W-1:0] ext_c [3];

  always_comb begin
    or_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_a[i][AW-1] ? (~in_a[i] + 1'b1) : in_a[i];
      or_c     = or_c | mag_c[i];
    end
    hb_c = '0;
    for (int b = 0; b < AW; b++) begin
      if (or_c[b]) hb_c = SHW'(b + 1);
    end
    sh_c = '0;
    if (int'(hb_c) > MAG_W) sh_c = SHW'(int'(hb_c) - MAG_W);
    for (int i = 0; i < 3; i++) begin
      ext_c[i] = {{MAG_W{1'b0}}, mag_c[i]} >> sh_c;
    end
  end

  logic             v1_r;
  logic [MAG_W-1:0] m1_r [3];
  logic [2:0]       sg1_r;
  logic [SW-1:0]    sd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]  <= ext_c[i][MAG_W-1:0];
        sg1_r[i] <= in_a[i][AW-1];
      end
      sd1_r <= in_side;
    end
  end

  // squares
  logic               v2_r;
  logic [2*MAG_W-1:0] sq2_r [3];
  logic [MAG_W-1:0]   m2_r [3];
  logic [2:0]         sg2_r;
  logic [SW-1:0]      sd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= m1_r[i] * m1_r[i];
      end
      m2_r  <= m1_r;
      sg2_r <= sg1_r;
      sd2_r <= sd1_r;
    end
  end

  // square root, one result bit per stage; entry 0 holds the sum of squares
  logic               vq_r   [ROOT_W+1];
  logic [SUMSQ_W-1:0] rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]  root_r [ROOT_W+1];
  logic [MAG_W-1:0]   mq_r   [ROOT_W+1][3];
  logic [2:0]         sgq_r  [ROOT_W+1];
  logic [SW-1:0]      sdq_r  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else if (en) begin
      vq_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= SUMSQ_W'(sq2_r[0]) + SUMSQ_W'(sq2_r[1]) + SUMSQ_W'(sq2_r[2]);
      root_r[0] <= '0;
      mq_r[0]   <= m2_r;
      sgq_r[0]  <= sg2_r;
      sdq_r[0]  <= sd2_r;
    end
  end

  for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - gi;
    logic [SUMSQ_W-1:0] trial_c;
    logic               fit_c;

    assign trial_c = ({{(SUMSQ_W-ROOT_W){1'b0}}, root_r[gi]} << (K + 1))
                   | (SUMSQ_W'(1) << (2 * K));
    assign fit_c   = rem_r[gi] >= trial_c;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[gi+1] <= 1'b0;
      end else if (en) begin
        vq_r[gi+1] <= vq_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi+1]  <= fit_c ? rem_r[gi] - trial_c : rem_r[gi];
        root_r[gi+1] <= fit_c ? (root_r[gi] | (ROOT_W'(1) << K)) : root_r[gi];
        mq_r[gi+1]   <= mq_r[gi];
        sgq_r[gi+1]  <= sgq_r[gi];
        sdq_r[gi+1]  <= sdq_r[gi];
      end
    end
  end

  // restoring division m * 2^frac / len, one quotient bit per stage
  logic              dv_v_r   [NS+1];
  logic [REM_W-1:0]  dv_rem_r [NS+1][3];
  logic [NS-1:0]     dv_q_r   [NS+1][3];
  logic [ROOT_W-1:0] dv_len_r [NS+1];
  logic [2:0]        dv_sg_r  [NS+1];
  logic [SW-1:0]     dv_sd_r  [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= vq_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= REM_W'(mq_r[ROOT_W][i]);
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0] <= root_r[ROOT_W];
      dv_sg_r[0]  <= sgq_r[ROOT_W];
      dv_sd_r[0]  <= sdq_r[ROOT_W];
    end
  end

  for (genvar gj = 0; gj < NS; gj++) begin : g_div
    localparam int B = NS - 1 - gj;
    logic             ge_c [3];
    logic [REM_W-1:0] nr_c [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge_c[i] = dv_rem_r[gj][i] >= REM_W'(dv_len_r[gj]);
        nr_c[i] = ge_c[i] ? dv_rem_r[gj][i] - REM_W'(dv_len_r[gj]) : dv_rem_r[gj][i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[gj+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[gj+1] <= dv_v_r[gj];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[gj+1][i] <= {nr_c[i][REM_W-2:0], 1'b0};
          dv_q_r[gj+1][i]   <= dv_q_r[gj][i] | (NS'(ge_c[i]) << B);
        end
        dv_len_r[gj+1] <= dv_len_r[gj];
        dv_sg_r[gj+1]  <= dv_sg_r[gj];
        dv_sd_r[gj+1]  <= dv_sd_r[gj];
      end
    end
  end

  // restore signs
  logic                 ov_r;
  logic [2:0][RW-1:0]   or_r;
  logic                 oz_r;
  logic [SW-1:0]        os_r;
  logic [RW-1:0]        qe_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe_c[i] = RW'(dv_q_r[NS][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        or_r[i] <= dv_sg_r[NS][i] ? (~qe_c[i] + 1'b1) : qe_c[i];
      end
      oz_r <= dv_len_r[NS] == '0;
      os_r <= dv_sd_r[NS];
    end
  end

  assign out_valid = ov_r;
  assign out_r     = or_r;
  assign out_zero  = oz_r;
  assign out_side  = os_r;

endmodule

/* hw/rtl/look_at_view_matrix.sv */
// look_at_view_matrix: one look vector per cycle sustained, unless out_stall holds a
// waiting result; depth is set mostly by the two normalizers, each
// a 32-stage square root followed by a FRAC_BITS+1 stage divider
// synchronous active-low reset clears valid bits and sets up to (0, 1.0, 0), position 0
// depends on lav_pkg and lav_norm
module look_at_view_matrix
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FIELD_W-1:0]   in_look_x,
  input  logic [FIELD_W-1:0]   in_look_y,
  input  logic [FIELD_W-1:0]   in_look_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   out_right_x,
  output logic [FIELD_W-1:0]   out_right_y,
  output logic [FIELD_W-1:0]   out_right_z,
  output logic [FIELD_W-1:0]   out_right_offset,
  output logic [FIELD_W-1:0]   out_upward_x,
  output logic [FIELD_W-1:0]   out_upward_y,
  output logic [FIELD_W-1:0]   out_upward_z,
  output logic [FIELD_W-1:0]   out_upward_offset,
  output logic [FIELD_W-1:0]   out_back_x,
  output logic [FIELD_W-1:0]   out_back_y,
  output logic [FIELD_W-1:0]   out_back_z,
  output logic [FIELD_W-1:0]   out_back_offset
);

  localparam int RW  = FRAC_BITS + 2;      // unit vector component, |x| <= 1.0
  localparam int PR  = FIELD_W + RW;       // up * w product
  localparam int DW  = PR + 2 - FRAC_BITS; // up . w
  localparam int PW  = DW + RW - FRAC_BITS + 1; // up with its w part removed
  localparam int UW  = FRAC_BITS + 5;      // cross product term
  localparam int OPW = UW + FIELD_W;       // basis * position
  localparam int OW  = OPW + 3 - FRAC_BITS; // negated offset before saturation
  localparam int SDW = 1 + 3 * RW;

  localparam logic signed [OW-1:0] SAT_HI = OW'(2147483647);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

  // whole pipeline moves together; it holds only when a result is waiting
  logic en;
  assign en       = !(out_valid & out_stall);
  assign in_stall = !en;

  // configuration registers, to be written only while idle; the block does not enforce it
  logic signed [FIELD_W-1:0] up_r  [3];
  logic signed [FIELD_W-1:0] pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r[0]  <= '0;
      up_r[1]  <= FIELD_W'(1) << FRAC_BITS;
      up_r[2]  <= '0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UP_X:  up_r[0]  <= cfg_data;
        REG_UP_Y:  up_r[1]  <= cfg_data;
        REG_UP_Z:  up_r[2]  <= cfg_data;
        REG_POS_X: pos_r[0] <= cfg_data;
        REG_POS_Y: pos_r[1] <= cfg_data;
        REG_POS_Z: pos_r[2] <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // first normalizer: look direction
  logic                 n1_v;
  logic [2:0][RW-1:0]   n1_r;
  logic                 n1_z;
  logic                 n1_s;

  lav_norm #(.AW(FIELD_W), .FRAC_BITS(FRAC_BITS), .SW(1)) u_norm_look (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid & en),
    .in_a     ({in_look_z, in_look_y, in_look_x}),
    .in_side  (1'b0),
    .out_valid(n1_v),
    .out_r    (n1_r),
    .out_zero (n1_z),
    .out_side (n1_s)
  );

  // w is the negated unit look vector
  logic signed [RW-1:0] w_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_c[i] = -$signed(n1_r[i]);
    end
  end

  // up . w products
  logic                 t1_v_r;
  logic                 t1_z_r;
  logic signed [RW-1:0] t1_w_r  [3];
  logic signed [PR-1:0] t1_pw_r [3];

  // sum and rescale to get d
  logic                   t2_v_r;
  logic                   t2_z_r;
  logic signed [RW-1:0]   t2_w_r [3];
  logic signed [DW-1:0]   t2_d_r;
  logic signed [PR+1:0]   dot_c;

  // d * w
  logic                     t3_v_r;
  logic                     t3_z_r;
  logic signed [RW-1:0]     t3_w_r  [3];
  logic signed [DW+RW-1:0]  t3_dw_r [3];

  // p = up - d w
  logic                 t4_v_r;
  logic                 t4_z_r;
  logic [2:0][RW-1:0]   t4_w_r;
  logic [2:0][PW-1:0]   t4_p_r;

  assign dot_c = (PR+2)'(t1_pw_r[0]) + (PR+2)'(t1_pw_r[1]) + (PR+2)'(t1_pw_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= n1_v;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      t4_v_r <= t3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_z_r <= n1_z | n1_s;
      t2_z_r <= t1_z_r;
      t3_z_r <= t2_z_r;
      t4_z_r <= t3_z_r;
      t2_d_r <= DW'(dot_c >>> FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        t1_w_r[i]  <= w_c[i];
        t1_pw_r[i] <= PR'(up_r[i]) * PR'(w_c[i]);
        t2_w_r[i]  <= t1_w_r[i];
        t3_w_r[i]  <= t2_w_r[i];
        t3_dw_r[i] <= (DW+RW)'(t2_d_r) * (DW+RW)'(t2_w_r[i]);
        t4_w_r[i]  <= t3_w_r[i];
        t4_p_r[i]  <= PW'(up_r[i]) - PW'(t3_dw_r[i] >>> FRAC_BITS);
      end
    end
  end

  // second normalizer: v from p, carrying w and the zero flag alongside
  logic                 n2_v;
  logic [2:0][RW-1:0]   n2_r;
  logic                 n2_z;
  logic [SDW-1:0]       n2_s;

  lav_norm #(.AW(PW), .FRAC_BITS(FRAC_BITS), .SW(SDW)) u_norm_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (t4_v_r),
    .in_a     (t4_p_r),
    .in_side  ({t4_z_r, t4_w_r}),
    .out_valid(n2_v),
    .out_r    (n2_r),
    .out_zero (n2_z),
    .out_side (n2_s)
  );

  logic signed [RW-1:0] v_c [3];
  logic signed [RW-1:0] w2_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_c[i]  = $signed(n2_r[i]);
      w2_c[i] = $signed(n2_s[i*RW +: RW]);
    end
  end

  // cross product terms
  logic                   t5_v_r;
  logic                   t5_z_r;
  logic signed [RW-1:0]   t5_vb_r [3];
  logic signed [RW-1:0]   t5_wb_r [3];
  logic signed [2*RW-1:0] t5_x_r  [6];

  // u = v x w
  logic                   t6_v_r;
  logic                   t6_z_r;
  logic signed [RW-1:0]   t6_vb_r [3];
  logic signed [RW-1:0]   t6_wb_r [3];
  logic signed [UW-1:0]   t6_u_r  [3];
  logic signed [2*RW:0]   cr_c    [3];

  // basis times position, basis rows as output fields
  logic                     t7_v_r;
  logic                     t7_z_r;
  logic signed [UW-1:0]     bas_c   [3][3];
  logic signed [OPW-1:0]    t7_op_r [3][3];
  logic [FIELD_W-1:0]       t7_b_r  [3][3];

  // offsets, saturation and zero masking into the output register
  logic signed [OPW+1:0]    osum_c [3];
  logic signed [OW-1:0]     oneg_c [3];
  logic [FIELD_W-1:0]       osat_c [3];
  logic                     out_v_r;
  logic [FIELD_W-1:0]       out_b_r   [3][3];
  logic [FIELD_W-1:0]       out_off_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_c[i] = (2*RW+1)'(t5_x_r[2*i]) - (2*RW+1)'(t5_x_r[2*i+1]);
    end
    for (int c = 0; c < 3; c++) begin
      bas_c[0][c] = t6_u_r[c];
      bas_c[1][c] = UW'(t6_vb_r[c]);
      bas_c[2][c] = UW'(t6_wb_r[c]);
    end
    for (int r = 0; r < 3; r++) begin
      osum_c[r] = (OPW+2)'(t7_op_r[r][0]) + (OPW+2)'(t7_op_r[r][1])
                + (OPW+2)'(t7_op_r[r][2]);
      oneg_c[r] = -OW'(osum_c[r] >>> FRAC_BITS);
      priority if (oneg_c[r] > SAT_HI) begin
        osat_c[r] = FIELD_W'(SAT_HI);
      end else if (oneg_c[r] < SAT_LO) begin
        osat_c[r] = FIELD_W'(SAT_LO);
      end else begin
        osat_c[r] = FIELD_W'(oneg_c[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t5_v_r  <= 1'b0;
      t6_v_r  <= 1'b0;
      t7_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      t5_v_r  <= n2_v;
      t6_v_r  <= t5_v_r;
      t7_v_r  <= t6_v_r;
      out_v_r <= t7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_z_r <= n2_z | n2_s[SDW-1];
      t5_vb_r <= v_c;
      t5_wb_r <= w2_c;
      // pairs for u.x, u.y, u.z
      t5_x_r[0] <= (2*RW)'(v_c[1]) * (2*RW)'(w2_c[2]);
      t5_x_r[1] <= (2*RW)'(v_c[2]) * (2*RW)'(w2_c[1]);
      t5_x_r[2] <= (2*RW)'(v_c[2]) * (2*RW)'(w2_c[0]);
      t5_x_r[3] <= (2*RW)'(v_c[0]) * (2*RW)'(w2_c[2]);
      t5_x_r[4] <= (2*RW)'(v_c[0]) * (2*RW)'(w2_c[1]);
      t5_x_r[5] <= (2*RW)'(v_c[1]) * (2*RW)'(w2_c[0]);

      t6_z_r  <= t5_z_r;
      t6_vb_r <= t5_vb_r;
      t6_wb_r <= t5_wb_r;
      for (int i = 0; i < 3; i++) begin
        t6_u_r[i] <= UW'(cr_c[i] >>> FRAC_BITS);
      end

      t7_z_r <= t6_z_r;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          t7_op_r[r][c] <= OPW'(bas_c[r][c]) * OPW'(pos_r[c]);
          t7_b_r[r][c]  <= FIELD_W'(bas_c[r][c]);
        end
      end

      // a zero-length look vector or a zero-length p (up zero or parallel to look) clears the whole result
      for (int r = 0; r < 3; r++) begin
        out_off_r[r] <= t7_z_r ? '0 : osat_c[r];
        for (int c = 0; c < 3; c++) begin
          out_b_r[r][c] <= t7_z_r ? '0 : t7_b_r[r][c];
        end
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_right_x       = out_b_r[0][0];
  assign out_right_y       = out_b_r[0][1];
  assign out_right_z       = out_b_r[0][2];
  assign out_right_offset  = out_off_r[0];
  assign out_upward_x      = out_b_r[1][0];
  assign out_upward_y      = out_b_r[1][1];
  assign out_upward_z      = out_b_r[1][2];
  assign out_upward_offset = out_off_r[1];
  assign out_back_x        = out_b_r[2][0];
  assign out_back_y        = out_b_r[2][1];
  assign out_back_z        = out_b_r[2][2];
  assign out_back_offset   = out_off_r[2];

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for the look-at view matrix block
// predicts each result row set locally and compares transfers in order
// depends on lav_pkg and look_at_view_matrix
module testbench
  import lav_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int NUM_FIELDS = 12;
  localparam int LATENCY = 2 * FRAC + 84;
  localparam int STALL_LIMIT = 20000;
  localparam logic [FIELD_W-1:0] ONE = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] MIN_NEG = 32'h8000_0000;

  typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] view_rows_t;

  typedef struct {
    logic [FIELD_W-1:0] x, y, z;
    bit                 typed;   // expectation written in the table
    view_rows_t         rows;
  } look_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FIELD_W-1:0] in_look_x = '0, in_look_y = '0, in_look_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FIELD_W-1:0] out_f [NUM_FIELDS];

  always #6 clk = ~clk;

  look_at_view_matrix #(.FRAC_BITS(FRAC)) u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_look_x, .in_look_y, .in_look_z,
    .out_valid, .out_stall,
    .out_right_x(out_f[0]), .out_right_y(out_f[1]), .out_right_z(out_f[2]),
    .out_right_offset(out_f[3]),
    .out_upward_x(out_f[4]), .out_upward_y(out_f[5]), .out_upward_z(out_f[6]),
    .out_upward_offset(out_f[7]),
    .out_back_x(out_f[8]), .out_back_y(out_f[9]), .out_back_z(out_f[10]),
    .out_back_offset(out_f[11])
  );

  // local copy of the camera registers
  longint cam_up [3];
  longint cam_pos [3];

  view_rows_t pending_views [$];
  int mismatches = 0;
  int idle_pct = 33;    // chance of a bubble or stall per cycle, 0 during the quiet stretch
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // fixed-point helpers
  // ---------------------------------------------------------------------------
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit vector with FRAC fraction bits; returns 0 on zero length
  function automatic bit unit_vec(input longint a [3], output longint r [3]);
    longint unsigned m [3];
    longint unsigned sumsq, len;
    for (int i = 0; i < 3; i++) m[i] = (a[i] < 0) ? longint'(-a[i]) : a[i];
    // halve until every magnitude fits in 31 bits
    while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = floor_root(sumsq);
    for (int i = 0; i < 3; i++) r[i] = 0;
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'((m[i] << FRAC) / len);
      if (a[i] < 0) r[i] = -r[i];
    end
    return 1'b1;
  endfunction

  // saturated minus dot product with the camera position
  function automatic logic [FIELD_W-1:0] neg_dot_pos(input longint b [3]);
    longint o;
    o = -((b[0] * cam_pos[0] + b[1] * cam_pos[1] + b[2] * cam_pos[2]) >>> FRAC);
    if (o > 64'sd2147483647) o = 64'sd2147483647;
    if (o < -64'sd2147483648) o = -64'sd2147483648;
    return o[FIELD_W-1:0];
  endfunction

  function automatic view_rows_t predict_view(logic [FIELD_W-1:0] lx, ly, lz);
    longint look [3], nl [3], w [3], p [3], v [3], u [3];
    longint d;
    view_rows_t rows;
    rows = '0;
    look[0] = longint'($signed(lx));
    look[1] = longint'($signed(ly));
    look[2] = longint'($signed(lz));
    if (!unit_vec(look, nl)) return rows;
    for (int i = 0; i < 3; i++) w[i] = -nl[i];
    d = (cam_up[0] * w[0] + cam_up[1] * w[1] + cam_up[2] * w[2]) >>> FRAC;
    for (int i = 0; i < 3; i++) p[i] = cam_up[i] - ((d * w[i]) >>> FRAC);
    if (!unit_vec(p, v)) return rows;
    u[0] = (v[1] * w[2] - v[2] * w[1]) >>> FRAC;
    u[1] = (v[2] * w[0] - v[0] * w[2]) >>> FRAC;
    u[2] = (v[0] * w[1] - v[1] * w[0]) >>> FRAC;
    for (int i = 0; i < 3; i++) begin
      rows[i]     = u[i][FIELD_W-1:0];
      rows[4 + i] = v[i][FIELD_W-1:0];
      rows[8 + i] = w[i][FIELD_W-1:0];
    end
    rows[3]  = neg_dot_pos(u);
    rows[7]  = neg_dot_pos(v);
    rows[11] = neg_dot_pos(w);
    return rows;
  endfunction

  // ---------------------------------------------------------------------------
  // register writes, only issued while nothing is in flight
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    // indexes past the position registers are ignored by the block
    case (idx)
      REG_UP_X:  cam_up[0]  = longint'($signed(val));
      REG_UP_Y:  cam_up[1]  = longint'($signed(val));
      REG_UP_Z:  cam_up[2]  = longint'($signed(val));
      REG_POS_X: cam_pos[0] = longint'($signed(val));
      REG_POS_Y: cam_pos[1] = longint'($signed(val));
      REG_POS_Z: cam_pos[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [FIELD_W-1:0] ux, uy, uz, px, py, pz);
    wait (pending_views.size() == 0);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_POS_Z, pz);
  endtask

  // ---------------------------------------------------------------------------
  // input transfers: drive at the falling edge, accept seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_look(logic [FIELD_W-1:0] lx, ly, lz, bit typed, view_rows_t rows);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_look_x = lx;
    in_look_y = ly;
    in_look_z = lz;
    do @(posedge clk); while (in_stall);
    pending_views.push_back(typed ? rows : predict_view(lx, ly, lz));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random component: mostly modest magnitudes, sometimes full range or zero
  function automatic logic [FIELD_W-1:0] rand_comp();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 5) return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
    if (pick < 8) return $urandom;
    if (pick < 9) return '0;
    return $urandom_range(1, 0) ? MAX_POS : MIN_NEG;
  endfunction

  task automatic send_random_look();
    logic [FIELD_W-1:0] lx, ly, lz;
    int k;
    view_rows_t none;
    none = '0;
    lx = rand_comp();
    ly = rand_comp();
    lz = rand_comp();
    // now and then look along the up vector to hit the degenerate basis
    if ($urandom_range(19, 0) == 0) begin
      k = $urandom_range(3, 1);
      lx = cam_up[0][FIELD_W-1:0] * k;
      ly = cam_up[1][FIELD_W-1:0] * k;
      lz = cam_up[2][FIELD_W-1:0] * k;
      if ($urandom_range(1, 0)) begin
        lx = -lx;
        ly = -ly;
        lz = -lz;
      end
    end
    send_look(lx, ly, lz, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // directed table, run with the reset camera (up = y, position at origin)
  // ---------------------------------------------------------------------------
  look_row_t look_table [$];

  function automatic look_row_t mk_row(logic [FIELD_W-1:0] x, y, z, bit typed,
                                       view_rows_t rows);
    look_row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.rows = rows;
    return r;
  endfunction

  function automatic void build_table();
    view_rows_t zeros, down_z;
    zeros = '0;
    down_z = '0;
    down_z[0] = ONE;    // u = +x
    down_z[5] = ONE;    // v = +y
    down_z[10] = ONE;   // w = +z
    // zero look vector gives an all-zero result
    look_table.push_back(mk_row('0, '0, '0, 1'b1, zeros));
    // looking down -z with up along y is the identity basis
    look_table.push_back(mk_row('0, '0, -ONE, 1'b1, down_z));
    // look parallel to up, both directions: the up vector collapses
    look_table.push_back(mk_row('0, ONE, '0, 1'b1, zeros));
    look_table.push_back(mk_row('0, 32'hfffb_0000, '0, 1'b1, zeros));
    look_table.push_back(mk_row('0, MAX_POS, '0, 1'b1, zeros));
    // extremes of the fields, checked against the predictor
    look_table.push_back(mk_row(MIN_NEG, MIN_NEG, MIN_NEG, 1'b0, zeros));
    look_table.push_back(mk_row(MAX_POS, MAX_POS, MAX_POS, 1'b0, zeros));
    look_table.push_back(mk_row(MIN_NEG, '0, '0, 1'b0, zeros));
    look_table.push_back(mk_row('0, '0, MAX_POS, 1'b0, zeros));
    look_table.push_back(mk_row(MAX_POS, MIN_NEG, 32'd1, 1'b0, zeros));
    look_table.push_back(mk_row(32'd1, '0, '0, 1'b0, zeros));
    look_table.push_back(mk_row(32'hffff_ffff, 32'd1, 32'hffff_ffff, 1'b0, zeros));
    look_table.push_back(mk_row(ONE, ONE, ONE, 1'b0, zeros));
    look_table.push_back(mk_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 1'b0, zeros));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls at the falling edge, compare at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99, 0) < idle_pct);
  end

  always @(posedge clk) begin
    view_rows_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing expected");
      end else begin
        want = pending_views.pop_front();
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (out_f[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h got %h", i, want[i], out_f[i]);
          end
        end
      end
    end
  end

  // watchdog: cycles in which neither channel moves a transfer, no register is written and work is outstanding
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we ||
        pending_views.size() == 0 && !in_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cam_up[0] = 0;
    cam_up[1] = 64'sd65536;
    cam_up[2] = 0;
    cam_pos[0] = 0;
    cam_pos[1] = 0;
    cam_pos[2] = 0;
    build_table();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (look_table[i])
      send_look(look_table[i].x, look_table[i].y, look_table[i].z,
                look_table[i].typed, look_table[i].rows);

    // several camera settings, extremes first; ignored indexes are written too
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_camera('0, '0, ONE, MAX_POS, MIN_NEG, MAX_POS);
        1: set_camera(MIN_NEG, MAX_POS, MIN_NEG, MIN_NEG, MAX_POS, MIN_NEG);
        2: set_camera('0, '0, '0, ONE, 32'hfffe_0000, 32'h0003_8000);
        default: set_camera(rand_comp(), rand_comp(), rand_comp(),
                            $urandom, $urandom, $urandom);
      endcase
      write_reg(3'd6, $urandom);
      write_reg(3'd7, $urandom);
      for (int n = 0; n < 128; n++) begin
        // a long stretch with no bubbles or stalls in the middle phase
        idle_pct = (ph == 2 && n >= 20 && n < 110) ? 0 : 33;
        send_random_look();
      end
    end
    idle_pct = 33;

    wait (pending_views.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/look_at_view_matrix.sv
tb/sv/testbench.sv
